// File: hdl/u2a_pkg.sv
// Shared types, constants and character mapping functions for the UTF-8 sanitizer.
`default_nettype none
package u2a_pkg;

    localparam int QDEPTH = 2;
    localparam int QAW    = 1;

    localparam int PADDR_W = 3;

    // register indexes (paddr bit 2)
    localparam logic REG_FALLBACK = 1'b0;
    localparam logic REG_KEEP     = 1'b1;

    localparam logic [7:0] FALLBACK_RST = 8'd63;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       has_byte;
        logic       end_of_text;
    } item_t;

    // head of the front queue as seen by the back end
    typedef struct packed {
        logic  valid;
        item_t item;
    } qhead_t;

    typedef struct packed {
        logic [1:0] n;
        logic [7:0] c0;
        logic [7:0] c1;
        logic [7:0] c2;
    } chars_t;

    // Latin-1 letter stripped to base; low byte zero means a single character
    function automatic logic [15:0] latin1_base(input logic [5:0] i);
        logic [15:0] r;
        unique case (i) inside
            [6'd0:6'd5]:   r = {"A", 8'd0};
            6'd6:          r = "AE";
            6'd7:          r = {"C", 8'd0};
            [6'd8:6'd11]:  r = {"E", 8'd0};
            [6'd12:6'd15]: r = {"I", 8'd0};
            6'd16:         r = {"D", 8'd0};
            6'd17:         r = {"N", 8'd0};
            [6'd18:6'd22]: r = {"O", 8'd0};
            6'd23:         r = {"x", 8'd0};
            6'd24:         r = {"O", 8'd0};
            [6'd25:6'd28]: r = {"U", 8'd0};
            6'd29:         r = {"Y", 8'd0};
            6'd30:         r = "Th";
            6'd31:         r = "ss";
            [6'd32:6'd37]: r = {"a", 8'd0};
            6'd38:         r = "ae";
            6'd39:         r = {"c", 8'd0};
            [6'd40:6'd43]: r = {"e", 8'd0};
            [6'd44:6'd47]: r = {"i", 8'd0};
            6'd48:         r = {"d", 8'd0};
            6'd49:         r = {"n", 8'd0};
            [6'd50:6'd54]: r = {"o", 8'd0};
            6'd55:         r = {"/", 8'd0};
            6'd56:         r = {"o", 8'd0};
            [6'd57:6'd60]: r = {"u", 8'd0};
            6'd61:         r = {"y", 8'd0};
            6'd62:         r = "th";
            default:       r = {"y", 8'd0};
        endcase
        return r;
    endfunction

    // map one valid code point to zero to three ASCII characters
    function automatic chars_t map_cp(input logic [20:0] cp, input logic [7:0] fb);
        chars_t      r;
        logic [15:0] l;
        r = '0;
        l = latin1_base(cp[5:0]);
        priority if (cp == 21'h0A) begin
            r.n = 2'd1; r.c0 = 8'h0A;
        end
        else if (cp == 21'h09) begin
            r.n = 2'd1; r.c0 = " ";
        end
        else if (cp < 21'h20 || cp == 21'h7F) begin
            r.n = 2'd0;
        end
        else if (cp <= 21'h7E) begin
            r.n = 2'd1; r.c0 = cp[7:0];
        end
        else if (cp == 21'hA0) begin
            r.n = 2'd1; r.c0 = " ";
        end
        else if (cp == 21'hAB || cp == 21'hBB || cp == 21'h201C || cp == 21'h201D ||
                 cp == 21'h201E || cp == 21'h2033) begin
            r.n = 2'd1; r.c0 = "\"";
        end
        else if (cp == 21'h2018 || cp == 21'h2019 || cp == 21'h201A ||
                 cp == 21'h2032) begin
            r.n = 2'd1; r.c0 = "'";
        end
        else if ((cp >= 21'h2010 && cp <= 21'h2015) || cp == 21'h2212 ||
                 cp == 21'h2022 || cp == 21'hB7) begin
            r.n = 2'd1; r.c0 = "-";
        end
        else if (cp == 21'h2026) begin
            r.n = 2'd3; r.c0 = "."; r.c1 = "."; r.c2 = ".";
        end
        else if (cp == 21'hB0) begin
            r.n = 2'd1; r.c0 = "*";
        end
        else if (cp >= 21'hC0 && cp <= 21'hFF) begin
            r.c0 = l[15:8];
            r.c1 = l[7:0];
            r.n  = (l[7:0] != 8'd0) ? 2'd2 : 2'd1;
        end
        else if ((cp >= 21'h300 && cp <= 21'h36F) || (cp >= 21'h200B && cp <= 21'h200F) ||
                 (cp >= 21'hFE00 && cp <= 21'hFE0F) || cp == 21'hFEFF ||
                 (cp >= 21'h1F3FB && cp <= 21'h1F3FF)) begin
            r.n = 2'd0;
        end
        else begin
            r.n = 2'd1; r.c0 = fb;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// File: hdl/u2a_if.sv
// Valid/ready channel interfaces for input bytes and output characters.
`default_nettype none
interface u2a_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       has_byte;
    logic       end_of_text;
    modport source (output valid, in_byte, has_byte, end_of_text, input ready);
    modport sink   (input valid, in_byte, has_byte, end_of_text, output ready);
endinterface

interface u2a_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       char_present;
    logic       text_done;
    logic [1:0] pending_bytes;
    modport source (output valid, out_char, char_present, text_done, pending_bytes,
                    input ready);
    modport sink   (input valid, out_char, char_present, text_done, pending_bytes,
                    output ready);
endinterface
`default_nettype wire

// File: hdl/u2a_front.sv
// Front end: accept requests, drop empty ones, queue the rest for the back end.
`default_nettype none
module u2a_front (
    input  wire logic        clk,
    input  wire logic        rst_n,
    u2a_in_if.sink           in_ch,
    output u2a_pkg::qhead_t  head,
    input  wire logic        pop
);
    import u2a_pkg::*;

    item_t            q_mem [QDEPTH];
    logic [QAW-1:0]   wr_reg, wr_next;
    logic [QAW-1:0]   rd_reg, rd_next;
    logic [QAW:0]     cnt_reg, cnt_next;
    logic             take, push, do_pop;

    assign in_ch.ready = (cnt_reg != QDEPTH[QAW:0]);
    assign take   = in_ch.valid && in_ch.ready;
    // an item with no byte and no end marker has no effect
    assign push   = take && (in_ch.has_byte || in_ch.end_of_text);
    assign do_pop = pop && (cnt_reg != '0);

    assign head.valid = (cnt_reg != '0);
    assign head.item  = q_mem[rd_reg];

    always_comb
    begin
        wr_next  = push   ? wr_reg + 1'b1 : wr_reg;
        rd_next  = do_pop ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg + {{QAW{1'b0}}, push} - {{QAW{1'b0}}, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_reg] <= '{in_byte: in_ch.in_byte, has_byte: in_ch.has_byte,
                               end_of_text: in_ch.end_of_text};
        end
    end

endmodule
`default_nettype wire

// File: hdl/u2a_back.sv
// Back end: pending buffer, strict decode, mapping and result sequencing.
`default_nettype none
module u2a_back (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire u2a_pkg::qhead_t head,
    output logic             pop,
    input  wire logic [7:0]  fallback_char,
    input  wire logic        keep_tail,
    u2a_out_if.source        out_ch
);
    import u2a_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_MAP  = 3'd2;
    localparam logic [2:0] S_EMIT = 3'd3;
    localparam logic [2:0] S_TAIL = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0]  state_reg, state_next;
    logic [7:0]  buf_reg [4];
    logic [7:0]  buf_next [4];
    logic [2:0]  count_reg, count_next;
    logic        eot_reg, eot_next;
    logic [20:0] cp_reg, cp_next;
    logic        usefb_reg, usefb_next;
    chars_t      chars_reg, chars_next;
    logic [1:0]  idx_reg, idx_next;

    logic        ov_reg, ov_next;
    logic [7:0]  oc_reg, oc_next;
    logic        op_reg, op_next;
    logic        od_reg, od_next;
    logic [1:0]  opn_reg, opn_next;
    logic        free;

    // decode of the buffer head
    logic [7:0]  b0;
    logic [2:0]  need;
    logic        is_ascii, is_lead, cont_ok, cp_bad;
    logic [20:0] cp_dec, mincp;
    logic [2:0]  drop;
    chars_t      mapped;

    assign free = !ov_reg || out_ch.ready;
    assign b0   = buf_reg[0];

    always_comb
    begin
        is_ascii = (b0 < 8'h80);
        is_lead  = 1'b1;
        need     = 3'd1;
        cp_dec   = {13'd0, b0};
        mincp    = '0;
        priority if (b0 >= 8'hC2 && b0 <= 8'hDF)
        begin
            need   = 3'd2;
            cp_dec = {10'd0, b0[4:0], buf_reg[1][5:0]};
            mincp  = 21'h80;
        end
        else if (b0 >= 8'hE0 && b0 <= 8'hEF)
        begin
            need   = 3'd3;
            cp_dec = {5'd0, b0[3:0], buf_reg[1][5:0], buf_reg[2][5:0]};
            mincp  = 21'h800;
        end
        else if (b0 >= 8'hF0 && b0 <= 8'hF4)
        begin
            need   = 3'd4;
            cp_dec = {b0[2:0], buf_reg[1][5:0], buf_reg[2][5:0], buf_reg[3][5:0]};
            mincp  = 21'h10000;
        end
        else
        begin
            is_lead = 1'b0;
        end
        cont_ok = ((need < 3'd2) || (buf_reg[1][7:6] == 2'b10)) &&
                  ((need < 3'd3) || (buf_reg[2][7:6] == 2'b10)) &&
                  ((need < 3'd4) || (buf_reg[3][7:6] == 2'b10));
        cp_bad  = (cp_dec < mincp) || (cp_dec > 21'h10FFFF) ||
                  (cp_dec >= 21'hD800 && cp_dec <= 21'hDFFF);
    end

    assign mapped = map_cp(cp_reg, fallback_char);

    always_comb
    begin
        state_next = state_reg;
        buf_next   = buf_reg;
        count_next = count_reg;
        eot_next   = eot_reg;
        cp_next    = cp_reg;
        usefb_next = usefb_reg;
        chars_next = chars_reg;
        idx_next   = idx_reg;
        pop        = 1'b0;
        drop       = 3'd0;
        ov_next    = ov_reg && !out_ch.ready;
        oc_next    = oc_reg;
        op_next    = op_reg;
        od_next    = od_reg;
        opn_next   = opn_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (head.valid)
                begin
                    pop      = 1'b1;
                    eot_next = head.item.end_of_text;
                    if (head.item.has_byte)
                    begin
                        buf_next[count_reg[1:0]] = head.item.in_byte;
                        count_next = count_reg + 3'd1;
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_TAIL;
                    end
                end
            end
            S_SCAN:
            begin
                if (count_reg == 3'd0)
                begin
                    state_next = S_TAIL;
                end
                else if (is_ascii)
                begin
                    cp_next = cp_dec; usefb_next = 1'b0; drop = 3'd1;
                    state_next = S_MAP;
                end
                else if (!is_lead)
                begin
                    usefb_next = 1'b1; drop = 3'd1;
                    state_next = S_MAP;
                end
                else if (count_reg < need)
                begin
                    state_next = S_TAIL;
                end
                else if (!cont_ok)
                begin
                    // rescan from the byte after the lead
                    usefb_next = 1'b1; drop = 3'd1;
                    state_next = S_MAP;
                end
                else
                begin
                    cp_next = cp_dec; usefb_next = cp_bad; drop = need;
                    state_next = S_MAP;
                end
                unique case (drop)
                    3'd1:
                    begin
                        buf_next[0] = buf_reg[1];
                        buf_next[1] = buf_reg[2];
                        buf_next[2] = buf_reg[3];
                    end
                    3'd2:
                    begin
                        buf_next[0] = buf_reg[2];
                        buf_next[1] = buf_reg[3];
                    end
                    3'd3: buf_next[0] = buf_reg[3];
                    default: ;
                endcase
                count_next = count_reg - drop;
            end
            S_MAP:
            begin
                chars_next = usefb_reg ? chars_t'{n: 2'd1, c0: fallback_char,
                                                 c1: 8'd0, c2: 8'd0} : mapped;
                idx_next   = 2'd0;
                state_next = (chars_next.n == 2'd0) ? S_SCAN : S_EMIT;
            end
            S_EMIT:
            begin
                if (free)
                begin
                    ov_next  = 1'b1;
                    op_next  = 1'b1;
                    od_next  = 1'b0;
                    opn_next = 2'd0;
                    unique case (idx_reg)
                        2'd0:    oc_next = chars_reg.c0;
                        2'd1:    oc_next = chars_reg.c1;
                        default: oc_next = chars_reg.c2;
                    endcase
                    if (idx_reg == chars_reg.n - 2'd1)
                        state_next = S_SCAN;
                    else
                        idx_next = idx_reg + 2'd1;
                end
            end
            S_TAIL:
            begin
                if (!eot_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (free)
                begin
                    ov_next    = 1'b1;
                    count_next = 3'd0;
                    if (count_reg != 3'd0 && !keep_tail)
                    begin
                        oc_next = fallback_char; op_next = 1'b1;
                        od_next = 1'b0; opn_next = 2'd0;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        oc_next = 8'd0; op_next = 1'b0; od_next = 1'b1;
                        opn_next = keep_tail ? count_reg[1:0] : 2'd0;
                        state_next = S_IDLE;
                    end
                end
            end
            S_DONE:
            begin
                if (free)
                begin
                    ov_next = 1'b1; oc_next = 8'd0; op_next = 1'b0;
                    od_next = 1'b1; opn_next = 2'd0;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg   <= buf_next;
        eot_reg   <= eot_next;
        cp_reg    <= cp_next;
        usefb_reg <= usefb_next;
        chars_reg <= chars_next;
        idx_reg   <= idx_next;
        oc_reg    <= oc_next;
        op_reg    <= op_next;
        od_reg    <= od_next;
        opn_reg   <= opn_next;
    end

    assign out_ch.valid         = ov_reg;
    assign out_ch.out_char      = oc_reg;
    assign out_ch.char_present  = op_reg;
    assign out_ch.text_done     = od_reg;
    assign out_ch.pending_bytes = opn_reg;

endmodule
`default_nettype wire

// File: hdl/utf8_to_ascii_sanitizer.sv
// Top level of the UTF-8 to ASCII sanitizer: config registers, front and back ends.
//
// Usage:
//   in_ch  takes one request per byte: in_byte, has_byte, end_of_text.
//          A request with neither a byte nor an end mark is dropped.
//   out_ch gives one item per output character (char_present=1) and,
//          after each end of text, one done item (text_done=1) carrying
//          pending_bytes when keep_tail is set and the text ended mid-sequence.
//   APB:   fallback_char at 0x0, keep_tail at 0x4; write only while idle.
// Sequencing:
//   A request is written into the queue and reaches the back end from its head.
//   Each byte is then appended, goes through a scan that finds nothing complete
//   and a tail check; each decoded sequence adds a scan and a map step plus an
//   emit step per output character, and an end of text adds a step per closing
//   result. The back end finishes one byte before it pops the next request.
//   A two-entry queue lets the front keep taking requests while the back
//   end works; one output register holds a result until the sink takes it.
// Reset: queue empty, pending buffer empty, registers back to '?' and 0.
// Stall: when a result waits and out_ch.ready is low the back end holds before
//   its next result; once the queue is full in_ch.ready drops.
`default_nettype none
module utf8_to_ascii_sanitizer (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    u2a_in_if.sink                             in_ch,
    u2a_out_if.source                          out_ch,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [u2a_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);
    import u2a_pkg::*;

    logic [7:0] fallback_reg, fallback_next;
    logic       keep_reg, keep_next;
    logic       wr_en;
    qhead_t     head;
    logic       pop;

    // registers are written on the access phase of an APB write
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb
    begin
        fallback_next = fallback_reg;
        keep_next     = keep_reg;
        if (wr_en)
        begin
            unique case (paddr[2])
                REG_FALLBACK: fallback_next = pwdata[7:0];
                REG_KEEP:     keep_next     = pwdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fallback_reg <= FALLBACK_RST;
            keep_reg     <= 1'b0;
        end
        else
        begin
            fallback_reg <= fallback_next;
            keep_reg     <= keep_next;
        end
    end

    assign prdata = (paddr[2] == REG_KEEP) ? {31'd0, keep_reg} : {24'd0, fallback_reg};

    // accept and queue requests
    u2a_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .in_ch (in_ch),
        .head  (head),
        .pop   (pop)
    );

    // decode, map and emit results
    u2a_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .pop           (pop),
        .fallback_char (fallback_reg),
        .keep_tail     (keep_reg),
        .out_ch        (out_ch)
    );

endmodule
`default_nettype wire

// File: hdl/u2a_checker.sv
// Port-level checks for the sanitizer, bound to the top level.
`default_nettype none
module u2a_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [7:0] out_char,
    input wire logic       char_present,
    input wire logic       text_done,
    input wire logic [1:0] pending_bytes,
    input wire logic       pready
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_char) &&
        $stable(char_present) && $stable(text_done) && $stable(pending_bytes))
        else $error("stalled result changed");

    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (char_present != text_done))
        else $error("result is neither character nor done");

    a_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && text_done |-> out_char == 8'd0)
        else $error("done item carries a character");

    a_char: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && char_present |-> pending_bytes == 2'd0)
        else $error("character item carries a pending count");

    a_ready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");
endmodule

bind utf8_to_ascii_sanitizer u2a_checker u_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_char      (out_ch.out_char),
    .char_present  (out_ch.char_present),
    .text_done     (out_ch.text_done),
    .pending_bytes (out_ch.pending_bytes),
    .pready        (pready)
);
`default_nettype wire

// File: sim/utf8_to_ascii_sanitizer_tb.sv
// Self-checking testbench for the UTF-8 to ASCII sanitizer: directed table plus random text.
`default_nettype none
module utf8_to_ascii_sanitizer_tb;
    import u2a_pkg::*;

    // one expected output item
    typedef struct packed {
        logic [7:0] ch;
        logic       present;
        logic       done;
        logic [1:0] pend;
    } out_item_t;

    // one row of the directed table; chk=1 means exp holds the typed-in answer
    typedef struct {
        logic [7:0] b;
        logic       hb;
        logic       eot;
        logic       chk;
        out_item_t  exp;
    } row_t;

    logic clk;
    logic rst_n;
    logic psel, penable, pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    u2a_in_if  in_ch ();
    u2a_out_if out_ch ();

    utf8_to_ascii_sanitizer dut (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // predictor state: own copy of configuration and pending buffer
    logic [7:0] fb_char;
    logic       keep_tail_q;
    logic [7:0] held [4];
    int         held_n;

    out_item_t expected_chars[$];
    int        errors;
    bit        no_idle;

    initial begin
        clk = 1'b0;
        forever
        begin
            #5 clk = 1'b1;
            #5 clk = 1'b0;
        end
    end

    // hard limit: far beyond the slowest correct run
    initial begin
        #20_000_000;
        $display("status: fail");
        $finish;
    end

    // append one item to the expected queue
    function automatic void add_expected(input out_item_t it);
        expected_chars = {expected_chars, it};
    endfunction

    function automatic void push_char(input logic [7:0] c);
        out_item_t it;
        it = '{ch: c, present: 1'b1, done: 1'b0, pend: 2'd0};
        add_expected(it);
    endfunction

    // Latin-1 letter to base string, one or two characters
    function automatic void push_latin1(input int idx);
        string s;
        case (idx)
            0, 1, 2, 3, 4, 5: s = "A";
            6: s = "AE";
            7: s = "C";
            8, 9, 10, 11: s = "E";
            12, 13, 14, 15: s = "I";
            16: s = "D";
            17: s = "N";
            18, 19, 20, 21, 22, 24: s = "O";
            23: s = "x";
            25, 26, 27, 28: s = "U";
            29: s = "Y";
            30: s = "Th";
            31: s = "ss";
            32, 33, 34, 35, 36, 37: s = "a";
            38: s = "ae";
            39: s = "c";
            40, 41, 42, 43: s = "e";
            44, 45, 46, 47: s = "i";
            48: s = "d";
            49: s = "n";
            50, 51, 52, 53, 54, 56: s = "o";
            55: s = "/";
            57, 58, 59, 60: s = "u";
            62: s = "th";
            default: s = "y";
        endcase
        for (int i = 0; i < s.len(); i++)
            push_char(s[i]);
    endfunction

    // transliterate one valid code point
    function automatic void transliterate(input int unsigned cp);
        if (cp == 'h0A) push_char(8'h0A);
        else if (cp == 'h09) push_char(" ");
        else if (cp < 'h20 || cp == 'h7F) ;
        else if (cp <= 'h7E) push_char(cp[7:0]);
        else if (cp == 'hA0) push_char(" ");
        else if (cp == 'hAB || cp == 'hBB || (cp >= 'h201C && cp <= 'h201E) || cp == 'h2033)
            push_char("\"");
        else if ((cp >= 'h2018 && cp <= 'h201A) || cp == 'h2032) push_char("'");
        else if ((cp >= 'h2010 && cp <= 'h2015) || cp == 'h2212 || cp == 'h2022 || cp == 'hB7)
            push_char("-");
        else if (cp == 'h2026)
        begin
            push_char("."); push_char("."); push_char(".");
        end
        else if (cp == 'hD7) push_char("x");
        else if (cp == 'hF7) push_char("/");
        else if (cp == 'hB0) push_char("*");
        else if (cp >= 'hC0 && cp <= 'hFF) push_latin1(cp - 'hC0);
        else if ((cp >= 'h300 && cp <= 'h36F) || (cp >= 'h200B && cp <= 'h200F) ||
                 (cp >= 'hFE00 && cp <= 'hFE0F) || cp == 'hFEFF ||
                 (cp >= 'h1F3FB && cp <= 'h1F3FF)) ;
        else push_char(fb_char);
    endfunction

    function automatic void drop_held(input int k);
        for (int i = 0; i + k < held_n; i++)
            held[i] = held[i + k];
        held_n -= k;
    endfunction

    // scan the pending buffer for complete sequences
    function automatic void scan_held();
        int unsigned cp, mincp;
        int need;
        bit ok;
        while (held_n > 0)
        begin
            ok = 1'b1;
            if (held[0] < 8'h80)
            begin
                transliterate(held[0]); drop_held(1); continue;
            end
            if (held[0] >= 8'hC2 && held[0] <= 8'hDF)
            begin
                need = 2; cp = held[0] & 8'h1F; mincp = 'h80;
            end
            else if (held[0] >= 8'hE0 && held[0] <= 8'hEF)
            begin
                need = 3; cp = held[0] & 8'h0F; mincp = 'h800;
            end
            else if (held[0] >= 8'hF0 && held[0] <= 8'hF4)
            begin
                need = 4; cp = held[0] & 8'h07; mincp = 'h10000;
            end
            else
            begin
                push_char(fb_char); drop_held(1); continue;
            end
            if (held_n < need) break;
            for (int i = 1; i < need; i++)
            begin
                if (held[i][7:6] != 2'b10)
                begin
                    ok = 1'b0; break;
                end
                cp = (cp << 6) | held[i][5:0];
            end
            if (!ok)
            begin
                push_char(fb_char); drop_held(1); continue;
            end
            if (cp < mincp || cp > 'h10FFFF || (cp >= 'hD800 && cp <= 'hDFFF))
                push_char(fb_char);
            else
                transliterate(cp);
            drop_held(need);
        end
    endfunction

    // predict all results of one accepted request
    function automatic void predict_request(input logic [7:0] b, input logic hb,
                                            input logic eot);
        out_item_t it;
        if (hb && held_n < 4)
        begin
            held[held_n] = b;
            held_n++;
            scan_held();
        end
        if (eot)
        begin
            it = '{ch: 8'd0, present: 1'b0, done: 1'b1, pend: 2'd0};
            if (held_n > 0)
            begin
                if (keep_tail_q) it.pend = held_n[1:0];
                else push_char(fb_char);
            end
            add_expected(it);
            held_n = 0;
        end
    endfunction

    // check each accepted output item against the oldest expectation
    always @(posedge clk)
    begin
        out_item_t got, want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got = '{ch: out_ch.out_char, present: out_ch.char_present,
                    done: out_ch.text_done, pend: out_ch.pending_bytes};
            if (expected_chars.size() == 0)
            begin
                $display("%0t unexpected output: actual %h", $time, got);
                errors++;
            end
            else
            begin
                want = expected_chars.pop_front();
                if (got !== want)
                begin
                    $display("%0t mismatch: expected ch=%h p=%b d=%b n=%0d actual ch=%h p=%b d=%b n=%0d",
                             $time, want.ch, want.present, want.done, want.pend,
                             got.ch, got.present, got.done, got.pend);
                    errors++;
                end
            end
        end
    end

    // sink side: stall at random about 21 percent of cycles, never during no_idle
    always @(posedge clk)
    begin
        if (!rst_n) out_ch.ready <= 1'b0;
        else out_ch.ready <= no_idle || ($urandom_range(99) >= 21);
    end

    // send one request, with a random idle gap first; valid stays high after it
    task automatic send_request(input logic [7:0] b, input logic hb, input logic eot);
        while (!no_idle && $urandom_range(99) < 21)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.in_byte     <= b;
        in_ch.has_byte    <= hb;
        in_ch.end_of_text <= eot;
        do @(posedge clk); while (!in_ch.ready);
        predict_request(b, hb, eot);
    endtask

    // APB write: setup then access; drains outstanding work first
    task automatic write_reg(input logic idx, input logic [31:0] val);
        wait_idle();
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (idx == REG_FALLBACK) fb_char = val[7:0];
        else keep_tail_q = val[0];
    endtask

    // drop valid, wait for all expected results, then the block's internal latency
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        while (expected_chars.size() != 0) @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    // random encoded sequence, surrogates and values above 0x10FFFF included, plus some noise
    task automatic send_random_char(input logic eot_last);
        logic [7:0] seq [4];
        int n, kind;
        int unsigned cp;
        kind = $urandom_range(99);
        if (kind < 30)
        begin
            n = 1; seq[0] = 8'($urandom_range(127));
        end
        else if (kind < 50)
        begin
            n = 2; cp = $urandom_range('h7FF, 'h80);
            seq[0] = 8'hC0 | cp[10:6]; seq[1] = 8'h80 | cp[5:0];
        end
        else if (kind < 70)
        begin
            n = 3;
            case ($urandom_range(3))
                0: cp = $urandom_range('h2040, 'h2000);
                1: cp = 'hFEFF;
                2: cp = $urandom_range('hFE0F, 'hFE00);
                default: cp = $urandom_range('hFFFF, 'h800);
            endcase
            seq[0] = 8'hE0 | cp[15:12]; seq[1] = 8'h80 | cp[11:6];
            seq[2] = 8'h80 | cp[5:0];
        end
        else if (kind < 82)
        begin
            n = 4;
            cp = $urandom_range(1) ? $urandom_range('h1F3FF, 'h1F3F8) :
                                     $urandom_range('h13FFFF, 'h10000);
            seq[0] = 8'hF0 | cp[20:18]; seq[1] = 8'h80 | cp[17:12];
            seq[2] = 8'h80 | cp[11:6]; seq[3] = 8'h80 | cp[5:0];
        end
        else
        begin
            // noise: raw bytes, possibly breaking a sequence
            n = $urandom_range(3, 1);
            for (int i = 0; i < n; i++) seq[i] = 8'($urandom_range(255));
        end
        for (int i = 0; i < n; i++)
            send_request(seq[i], 1'b1, eot_last && (i == n - 1));
    endtask

    row_t dir [$];

    function automatic row_t mk(input logic [7:0] b, input logic hb, input logic eot);
        mk = '{b: b, hb: hb, eot: eot, chk: 1'b0, exp: '0};
    endfunction

    function automatic void add_row(input row_t r);
        dir = {dir, r};
    endfunction

    initial begin
        int n_items;
        errors = 0;
        no_idle = 1'b0;
        fb_char = FALLBACK_RST;
        keep_tail_q = 1'b0;
        held_n = 0;
        rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        in_ch.valid = 1'b0; in_ch.in_byte = '0; in_ch.has_byte = 1'b0;
        in_ch.end_of_text = 1'b0;
        out_ch.ready = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table: extremes, typography, bad leads, overlong, surrogate,
        // too large, bad continuation rescan, truncated tail, empty and end-only
        add_row('{b: 8'h41, hb: 1, eot: 0, chk: 1, exp: '{8'h41, 1, 0, 0}});
        add_row(mk(8'h00, 1, 0));
        add_row(mk(8'h09, 1, 0));
        add_row(mk(8'h7F, 1, 0));
        add_row('{b: 8'hFF, hb: 1, eot: 0, chk: 1, exp: '{8'd63, 1, 0, 0}});
        add_row('{b: 8'h80, hb: 1, eot: 0, chk: 1, exp: '{8'd63, 1, 0, 0}});
        add_row(mk(8'hC0, 1, 0));
        add_row(mk(8'hE2, 1, 0)); add_row(mk(8'h80, 1, 0));
        add_row(mk(8'hA6, 1, 0));
        add_row(mk(8'hC3, 1, 0)); add_row(mk(8'h9F, 1, 0));
        add_row(mk(8'hED, 1, 0)); add_row(mk(8'hA0, 1, 0));
        add_row(mk(8'h80, 1, 0));
        add_row(mk(8'hF4, 1, 0)); add_row(mk(8'h90, 1, 0));
        add_row(mk(8'h80, 1, 0)); add_row(mk(8'h80, 1, 0));
        add_row(mk(8'hE0, 1, 0)); add_row(mk(8'h41, 1, 0));
        add_row(mk(8'h42, 1, 0));
        add_row(mk(8'h00, 0, 0));
        add_row(mk(8'hF0, 1, 1));
        add_row('{b: 8'h00, hb: 0, eot: 1, chk: 1, exp: '{8'd0, 0, 1, 0}});

        foreach (dir[i])
        begin
            // a typed-in answer must be the only thing this row produces
            if (dir[i].chk) wait_idle();
            send_request(dir[i].b, dir[i].hb, dir[i].eot);
            if (dir[i].chk && (expected_chars.size() != 1 || expected_chars[0] !== dir[i].exp))
            begin
                $display("%0t table row %0d: expected %h actual %h", $time, i,
                         dir[i].exp, expected_chars.size() ? expected_chars[0] : '0);
                errors++;
            end
        end

        // random phases over several register settings, extremes included
        n_items = 0;
        for (int ph = 0; ph < 6; ph++)
        begin
            write_reg(REG_FALLBACK, (ph == 1) ? 32'd0 : (ph == 2) ? 32'hFF :
                                    $urandom_range(255));
            write_reg(REG_KEEP, {31'd0, ph[0]});
            no_idle = (ph == 3);
            for (int k = 0; k < 30; k++)
            begin
                send_random_char($urandom_range(9) == 0);
                if ($urandom_range(29) == 0)
                    send_request(8'($urandom_range(255)), 1'b0, 1'b0);
            end
            // close the text with a possibly truncated tail
            if ($urandom_range(1))
                send_request(8'hF0 | 8'($urandom_range(4)), 1'b1, 1'b0);
            send_request(8'h00, 1'b0, 1'b1);
        end
        no_idle = 1'b0;
        wait_idle();

        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
`default_nettype wire

// File: filelist.f
hdl/u2a_pkg.sv
hdl/u2a_if.sv
hdl/u2a_front.sv
hdl/u2a_back.sv
hdl/utf8_to_ascii_sanitizer.sv
hdl/u2a_checker.sv
sim/utf8_to_ascii_sanitizer_tb.sv
